>>> design/oki_pkg.sv
// Shared types, widths and constants for the three-wheel omni inverse kinematics block.
// Used by every module of the block; no dependencies.
`default_nettype none

package oki_pkg;

    // Fraction bits of the sine, cosine and wheel coefficients
    localparam int TRIG_FRAC_BITS = 15;

    localparam int FIELD_W  = 16;
    localparam int SPEED_W  = 24;
    localparam int Q30_W    = 30;                   // x, x^2 and partial products
    localparam int T_W      = 31;                   // Horner term, reaches 1.0 in Q30
    localparam int BASE_W   = TRIG_FRAC_BITS + 1;   // rounded base value, 0 .. 1.0
    localparam int TRIG_W   = TRIG_FRAC_BITS + 2;   // signed sine / cosine
    localparam int KPROD_W  = 2 * TRIG_W;
    localparam int SUM_W    = 2 * TRIG_FRAC_BITS + 5;
    localparam int COEF_W   = TRIG_FRAC_BITS + 3;
    localparam int PROD_W   = COEF_W + FIELD_W;
    localparam int TURN_W   = 2 * FIELD_W + 1;
    localparam int NEG_W    = TRIG_FRAC_BITS + 26;
    localparam int QUO_W    = NEG_W - TRIG_FRAC_BITS;
    localparam int NUM_CELLS  = 5;
    localparam int NUM_WHEELS = 3;
    localparam int RECIP_W  = 32;
    localparam int SHIFT_W  = 6;

    localparam logic [FIELD_W-1:0]     GAIN_RESET   = 16'd256;
    localparam logic [14:0]            QUARTER_TURN = 15'd16384;
    localparam logic [13:0]            EIGHTH_TURN  = 14'd8192;
    localparam logic [31:0]            PI_Q30       = 32'd3373259426;
    localparam logic [T_W-1:0]         ONE_Q30      = {1'b1, 30'd0};
    localparam logic [T_W-1:0]         TRIG_ROUND   = T_W'(1) << (29 - TRIG_FRAC_BITS);
    localparam logic [63:0]            HALF_SQRT3_Q30 = 64'd929887697;
    localparam logic signed [TRIG_W-1:0] HALF_SQRT3 =
        TRIG_W'((HALF_SQRT3_Q30 + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));

    localparam logic signed [QUO_W-1:0] SPEED_MAX = QUO_W'(24'sh7FFFFF);
    localparam logic signed [QUO_W-1:0] SPEED_MIN = QUO_W'(24'sh800000);
    localparam logic signed [NEG_W-1:0] TRUNC_BIAS =
        NEG_W'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

    // floor(n / d) == (n * M) >> s for n < 2^30, s = 30 + ceil(log2 d), M = ceil(2^s / d)
    localparam logic [63:0] RECIP_72 = ((64'd1 << 37) + 64'd71) / 64'd72;
    localparam logic [63:0] RECIP_42 = ((64'd1 << 36) + 64'd41) / 64'd42;
    localparam logic [63:0] RECIP_20 = ((64'd1 << 35) + 64'd19) / 64'd20;
    localparam logic [63:0] RECIP_6  = ((64'd1 << 33) + 64'd5) / 64'd6;
    localparam logic [63:0] RECIP_90 = ((64'd1 << 37) + 64'd89) / 64'd90;
    localparam logic [63:0] RECIP_56 = ((64'd1 << 36) + 64'd55) / 64'd56;
    localparam logic [63:0] RECIP_30 = ((64'd1 << 35) + 64'd29) / 64'd30;
    localparam logic [63:0] RECIP_12 = ((64'd1 << 34) + 64'd11) / 64'd12;
    localparam logic [63:0] RECIP_2  = ((64'd1 << 31) + 64'd1) / 64'd2;

    // Sine lane idles in the first cell: a zero reciprocal keeps its term at 1.0
    localparam logic [RECIP_W-1:0] SIN_RECIP [NUM_CELLS] = '{
        32'd0, RECIP_W'(RECIP_72), RECIP_W'(RECIP_42), RECIP_W'(RECIP_20), RECIP_W'(RECIP_6)
    };
    localparam logic [SHIFT_W-1:0] SIN_SHIFT [NUM_CELLS] = '{
        6'd31, 6'd37, 6'd36, 6'd35, 6'd33
    };
    localparam logic [RECIP_W-1:0] COS_RECIP [NUM_CELLS] = '{
        RECIP_W'(RECIP_90), RECIP_W'(RECIP_56), RECIP_W'(RECIP_30),
        RECIP_W'(RECIP_12), RECIP_W'(RECIP_2)
    };
    localparam logic [SHIFT_W-1:0] COS_SHIFT [NUM_CELLS] = '{
        6'd37, 6'd36, 6'd35, 6'd34, 6'd31
    };

    typedef enum logic [1:0] {
        QUAD_FIRST,
        QUAD_SECOND,
        QUAD_THIRD,
        QUAD_FOURTH
    } oki_quad_t;

    typedef struct packed {
        oki_quad_t                  quad;
        logic                       swap;
        logic signed [FIELD_W-1:0]  vel_x;
        logic signed [FIELD_W-1:0]  vel_y;
        logic signed [FIELD_W-1:0]  turn_rate;
    } oki_side_t;

    typedef struct packed {
        logic [Q30_W-1:0] x;
        logic [Q30_W-1:0] x2;
        logic [T_W-1:0]   t_sin;
        logic [T_W-1:0]   t_cos;
        oki_side_t        side;
    } oki_lane_t;

    typedef struct packed {
        logic signed [COEF_W-1:0]  s0;
        logic signed [COEF_W-1:0]  c0;
        logic signed [COEF_W-1:0]  s1;
        logic signed [COEF_W-1:0]  c1;
        logic signed [COEF_W-1:0]  s2;
        logic signed [COEF_W-1:0]  c2;
        logic signed [TURN_W-1:0]  turn;
        logic signed [FIELD_W-1:0] vel_x;
        logic signed [FIELD_W-1:0] vel_y;
    } oki_coef_t;

    // floor((v + 2^(F-1)) / 2^F) on a signed Q2F value
    function automatic logic signed [COEF_W-1:0] round_q2f(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] b;
        b = v + (SUM_W'(1) <<< (TRIG_FRAC_BITS - 1));
        return COEF_W'(b >>> TRIG_FRAC_BITS);
    endfunction

endpackage

`default_nettype wire

>>> design/oki_front.sv
// Front of the trig pipeline: folds the heading to an octant, scales it to radians
// in Q30 and squares it. Depends on oki_pkg.
`default_nettype none

module oki_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [15:0]                  heading_angle,
    input  wire logic signed [15:0]           vel_x,
    input  wire logic signed [15:0]           vel_y,
    input  wire logic signed [15:0]           turn_rate,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output oki_pkg::oki_lane_t                out_lane
);
    import oki_pkg::*;

    logic               a_v_reg;
    logic [Q30_W-1:0]   x_reg;
    oki_side_t          side_reg;
    logic               b_v_reg;
    oki_lane_t          lane_reg;

    logic               a_ready;
    logic               b_ready;
    logic [13:0]        offset;
    logic [13:0]        fold;
    logic [45:0]        pi_prod;
    logic [59:0]        sq_prod;
    logic [Q30_W-1:0]   x_next;
    oki_side_t          side_next;
    oki_lane_t          lane_next;

    assign b_ready  = !b_v_reg || out_ready;
    assign a_ready  = !a_v_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        offset  = heading_angle[13:0];
        side_next.quad      = oki_quad_t'(heading_angle[15:14]);
        side_next.swap      = offset > EIGHTH_TURN;
        side_next.vel_x     = vel_x;
        side_next.vel_y     = vel_y;
        side_next.turn_rate = turn_rate;
        // past the octant boundary work from the far end of the quadrant
        fold    = side_next.swap ? 14'(QUARTER_TURN - {1'b0, offset}) : offset;
        pi_prod = 46'(fold) * 46'(PI_Q30);
        x_next  = pi_prod[44:15];
    end

    always_comb begin
        sq_prod         = 60'(x_reg) * 60'(x_reg);
        lane_next.x     = x_reg;
        lane_next.x2    = sq_prod[59:30];
        lane_next.t_sin = ONE_Q30;
        lane_next.t_cos = ONE_Q30;
        lane_next.side  = side_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_v_reg <= in_valid;
            end
            if (b_ready) begin
                b_v_reg <= a_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            x_reg    <= x_next;
            side_reg <= side_next;
        end
        if (b_ready) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = b_v_reg;
    assign out_lane  = lane_reg;

endmodule

`default_nettype wire

>>> design/oki_cell.sv
// One Horner cell: multiplies both sine and cosine terms by x^2, divides by the
// cell's constants through a reciprocal and hands the new terms on. Depends on oki_pkg.
`default_nettype none

module oki_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [oki_pkg::RECIP_W-1:0]   recip_sin,
    input  wire logic [oki_pkg::SHIFT_W-1:0]   shift_sin,
    input  wire logic [oki_pkg::RECIP_W-1:0]   recip_cos,
    input  wire logic [oki_pkg::SHIFT_W-1:0]   shift_cos,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire oki_pkg::oki_lane_t            in_lane,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output oki_pkg::oki_lane_t                 out_lane
);
    import oki_pkg::*;

    logic               a_v_reg;
    logic [Q30_W-1:0]   ps_reg;
    logic [Q30_W-1:0]   pc_reg;
    oki_lane_t          a_lane_reg;
    logic               b_v_reg;
    oki_lane_t          lane_reg;

    logic               a_ready;
    logic               b_ready;
    logic [60:0]        ms_prod;
    logic [60:0]        mc_prod;
    logic [Q30_W-1:0]   ps_next;
    logic [Q30_W-1:0]   pc_next;
    logic [61:0]        ds_prod;
    logic [61:0]        dc_prod;
    logic [Q30_W-1:0]   qs;
    logic [Q30_W-1:0]   qc;
    oki_lane_t          lane_next;

    assign b_ready  = !b_v_reg || out_ready;
    assign a_ready  = !a_v_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        ms_prod = 61'(in_lane.x2) * 61'(in_lane.t_sin);
        mc_prod = 61'(in_lane.x2) * 61'(in_lane.t_cos);
        ps_next = ms_prod[59:30];
        pc_next = mc_prod[59:30];
    end

    always_comb begin
        ds_prod = 62'(ps_reg) * 62'(recip_sin);
        dc_prod = 62'(pc_reg) * 62'(recip_cos);
        qs      = Q30_W'(ds_prod >> shift_sin);
        qc      = Q30_W'(dc_prod >> shift_cos);
        lane_next       = a_lane_reg;
        lane_next.t_sin = ONE_Q30 - T_W'(qs);
        lane_next.t_cos = ONE_Q30 - T_W'(qc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_v_reg <= in_valid;
            end
            if (b_ready) begin
                b_v_reg <= a_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            ps_reg     <= ps_next;
            pc_reg     <= pc_next;
            a_lane_reg <= in_lane;
        end
        if (b_ready) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = b_v_reg;
    assign out_lane  = lane_reg;

endmodule

`default_nettype wire

>>> design/oki_coef.sv
// Finishes sine and cosine, maps the quadrant and forms the three wheel coefficient
// pairs plus the scaled turn term. Depends on oki_pkg.
`default_nettype none

module oki_coef (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [oki_pkg::FIELD_W-1:0]   radius_gain,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire oki_pkg::oki_lane_t            in_lane,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output oki_pkg::oki_coef_t                 out_coef
);
    import oki_pkg::*;

    logic                       c1_v_reg;
    logic [Q30_W-1:0]           sin_reg;
    logic [T_W-1:0]             cos_reg;
    oki_side_t                  c1_side_reg;
    logic                       c2_v_reg;
    logic signed [TRIG_W-1:0]   s_reg;
    logic signed [TRIG_W-1:0]   c_reg;
    logic signed [KPROD_W-1:0]  sk_reg;
    logic signed [KPROD_W-1:0]  ck_reg;
    oki_side_t                  c2_side_reg;
    logic                       c3_v_reg;
    oki_coef_t                  coef_reg;

    logic                       c1_ready;
    logic                       c2_ready;
    logic                       c3_ready;
    logic [60:0]                sin_prod;
    logic [T_W-1:0]             sin_rnd;
    logic [T_W-1:0]             cos_rnd;
    logic signed [TRIG_W-1:0]   sb;
    logic signed [TRIG_W-1:0]   cb;
    logic signed [TRIG_W-1:0]   bs;
    logic signed [TRIG_W-1:0]   bc;
    logic signed [TRIG_W-1:0]   s_next;
    logic signed [TRIG_W-1:0]   c_next;
    logic signed [SUM_W-1:0]    sk_w;
    logic signed [SUM_W-1:0]    ck_w;
    logic signed [SUM_W-1:0]    s_half;
    logic signed [SUM_W-1:0]    c_half;
    oki_coef_t                  coef_next;

    assign c3_ready = !c3_v_reg || out_ready;
    assign c2_ready = !c2_v_reg || c3_ready;
    assign c1_ready = !c1_v_reg || c2_ready;
    assign in_ready = c1_ready;

    assign sin_prod = 61'(in_lane.x) * 61'(in_lane.t_sin);

    always_comb begin
        sin_rnd = T_W'(sin_reg) + TRIG_ROUND;
        cos_rnd = cos_reg + TRIG_ROUND;
        bs = $signed(TRIG_W'(BASE_W'(sin_rnd >> (30 - TRIG_FRAC_BITS))));
        bc = $signed(TRIG_W'(BASE_W'(cos_rnd >> (30 - TRIG_FRAC_BITS))));
        // beyond the octant boundary the series ran on the complement angle
        sb = c1_side_reg.swap ? bc : bs;
        cb = c1_side_reg.swap ? bs : bc;
        case (c1_side_reg.quad)
            QUAD_FIRST: begin
                s_next = sb;
                c_next = cb;
            end
            QUAD_SECOND: begin
                s_next = cb;
                c_next = -sb;
            end
            QUAD_THIRD: begin
                s_next = -sb;
                c_next = -cb;
            end
            QUAD_FOURTH: begin
                s_next = -cb;
                c_next = sb;
            end
            default: begin
                s_next = sb;
                c_next = cb;
            end
        endcase
    end

    always_comb begin
        sk_w   = SUM_W'(sk_reg);
        ck_w   = SUM_W'(ck_reg);
        s_half = SUM_W'(s_reg) <<< (TRIG_FRAC_BITS - 1);
        c_half = SUM_W'(c_reg) <<< (TRIG_FRAC_BITS - 1);
        coef_next.s0    = round_q2f(sk_w + c_half);
        coef_next.c0    = round_q2f(ck_w - s_half);
        coef_next.s1    = round_q2f(c_half - sk_w);
        coef_next.c1    = round_q2f(-ck_w - s_half);
        coef_next.s2    = -COEF_W'(c_reg);
        coef_next.c2    = COEF_W'(s_reg);
        coef_next.turn  = TURN_W'($signed({1'b0, radius_gain})) *
                          TURN_W'(c2_side_reg.turn_rate);
        coef_next.vel_x = c2_side_reg.vel_x;
        coef_next.vel_y = c2_side_reg.vel_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
            c3_v_reg <= 1'b0;
        end else begin
            if (c1_ready) begin
                c1_v_reg <= in_valid;
            end
            if (c2_ready) begin
                c2_v_reg <= c1_v_reg;
            end
            if (c3_ready) begin
                c3_v_reg <= c2_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c1_ready) begin
            sin_reg     <= sin_prod[59:30];
            cos_reg     <= in_lane.t_cos;
            c1_side_reg <= in_lane.side;
        end
        if (c2_ready) begin
            s_reg       <= s_next;
            c_reg       <= c_next;
            sk_reg      <= KPROD_W'(s_next) * KPROD_W'(HALF_SQRT3);
            ck_reg      <= KPROD_W'(c_next) * KPROD_W'(HALF_SQRT3);
            c2_side_reg <= c1_side_reg;
        end
        if (c3_ready) begin
            coef_reg <= coef_next;
        end
    end

    assign out_valid = c3_v_reg;
    assign out_coef  = coef_reg;

endmodule

`default_nettype wire

>>> design/oki_mix.sv
// Applies the coefficients to the velocities, subtracts the turn term, truncates
// toward zero and saturates the three wheel speeds. Depends on oki_pkg.
`default_nettype none

module oki_mix (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire oki_pkg::oki_coef_t                            in_coef,
    output logic                                               out_valid,
    input  wire logic                                          out_ready,
    output logic [oki_pkg::NUM_WHEELS*oki_pkg::SPEED_W-1:0]    out_speed
);
    import oki_pkg::*;

    logic                       m1_v_reg;
    logic signed [PROD_W-1:0]   p_reg [NUM_WHEELS];
    logic signed [PROD_W-1:0]   q_reg [NUM_WHEELS];
    logic signed [NEG_W-1:0]    turn_reg;
    logic                       m2_v_reg;
    logic signed [NEG_W-1:0]    neg_reg [NUM_WHEELS];
    logic                       m3_v_reg;
    logic [SPEED_W-1:0]         speed_reg [NUM_WHEELS];

    logic                       m1_ready;
    logic                       m2_ready;
    logic                       m3_ready;
    logic signed [COEF_W-1:0]   sc [NUM_WHEELS];
    logic signed [COEF_W-1:0]   cc [NUM_WHEELS];
    logic signed [NEG_W-1:0]    neg_next [NUM_WHEELS];
    logic signed [NEG_W-1:0]    adj [NUM_WHEELS];
    logic signed [QUO_W-1:0]    quo [NUM_WHEELS];
    logic [SPEED_W-1:0]         speed_next [NUM_WHEELS];

    assign m3_ready = !m3_v_reg || out_ready;
    assign m2_ready = !m2_v_reg || m3_ready;
    assign m1_ready = !m1_v_reg || m2_ready;
    assign in_ready = m1_ready;

    always_comb begin
        sc[0] = in_coef.s0;
        cc[0] = in_coef.c0;
        sc[1] = in_coef.s1;
        cc[1] = in_coef.c1;
        sc[2] = in_coef.s2;
        cc[2] = in_coef.c2;
    end

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            neg_next[k] = NEG_W'(p_reg[k]) - NEG_W'(q_reg[k]) - turn_reg;
            // bias negatives so the arithmetic shift truncates toward zero
            adj[k] = neg_reg[k] + (neg_reg[k][NEG_W-1] ? TRUNC_BIAS : '0);
            quo[k] = QUO_W'(adj[k] >>> TRIG_FRAC_BITS);
            if (quo[k] > SPEED_MAX) begin
                speed_next[k] = SPEED_W'(SPEED_MAX);
            end else if (quo[k] < SPEED_MIN) begin
                speed_next[k] = SPEED_W'(SPEED_MIN);
            end else begin
                speed_next[k] = SPEED_W'(quo[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
        end else begin
            if (m1_ready) begin
                m1_v_reg <= in_valid;
            end
            if (m2_ready) begin
                m2_v_reg <= m1_v_reg;
            end
            if (m3_ready) begin
                m3_v_reg <= m2_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m1_ready) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                p_reg[k] <= PROD_W'(sc[k]) * PROD_W'(in_coef.vel_x);
                q_reg[k] <= PROD_W'(cc[k]) * PROD_W'(in_coef.vel_y);
            end
            turn_reg <= NEG_W'(in_coef.turn) <<< (TRIG_FRAC_BITS - 8);
        end
        if (m2_ready) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                neg_reg[k] <= neg_next[k];
            end
        end
        if (m3_ready) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                speed_reg[k] <= speed_next[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            out_speed[k*SPEED_W +: SPEED_W] = speed_reg[k];
        end
    end

    assign out_valid = m3_v_reg;

endmodule

`default_nettype wire

>>> design/omni_wheel_inverse_kinematics_top.sv
// Top level of the three-wheel omni inverse kinematics block: stream ports, the radius
// gain register and the front, Horner cell chain, coefficient and mix stages. Uses oki_pkg.
//
//   Channel   Direction  Payload (low bit first)
//   s_        in         heading_angle, vel_x, vel_y, turn_rate (4 x 16 bits)
//   m_        out        wheel0_speed, wheel1_speed, wheel2_speed (3 x 24 bits)
//   cfg_wr    in         wheel_radius_gain (16 bits, unsigned Q8.8)
//
// One transfer in per cycle while m_ accepts, one result per item; the stages are
// 2 front stages, 5 two-stage Horner cells, 3 coefficient and 3 mix stages.
// Every stage register carries its own valid and loads whenever it is empty or its
// successor moves, so a stalled m_ side fills bubbles before s_tready drops.
// Synchronous active-low reset empties the pipeline and sets the gain to 1.0.
`default_nettype none

module omni_wheel_inverse_kinematics_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,   // wheel_radius_gain
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,       // heading_angle, vel_x, vel_y, turn_rate
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata        // wheel0_speed, wheel1_speed, wheel2_speed
);
    import oki_pkg::*;

    logic [FIELD_W-1:0] gain_reg;

    logic       lane_valid [NUM_CELLS+1];
    logic       lane_ready [NUM_CELLS+1];
    oki_lane_t  lane       [NUM_CELLS+1];
    logic       coef_valid;
    logic       coef_ready;
    oki_coef_t  coef;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    oki_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .heading_angle (s_tdata[15:0]),
        .vel_x         ($signed(s_tdata[31:16])),
        .vel_y         ($signed(s_tdata[47:32])),
        .turn_rate     ($signed(s_tdata[63:48])),
        .out_valid     (lane_valid[0]),
        .out_ready     (lane_ready[0]),
        .out_lane      (lane[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        oki_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .recip_sin (SIN_RECIP[g]),
            .shift_sin (SIN_SHIFT[g]),
            .recip_cos (COS_RECIP[g]),
            .shift_cos (COS_SHIFT[g]),
            .in_valid  (lane_valid[g]),
            .in_ready  (lane_ready[g]),
            .in_lane   (lane[g]),
            .out_valid (lane_valid[g+1]),
            .out_ready (lane_ready[g+1]),
            .out_lane  (lane[g+1])
        );
    end

    oki_coef u_coef (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .radius_gain (gain_reg),
        .in_valid    (lane_valid[NUM_CELLS]),
        .in_ready    (lane_ready[NUM_CELLS]),
        .in_lane     (lane[NUM_CELLS]),
        .out_valid   (coef_valid),
        .out_ready   (coef_ready),
        .out_coef    (coef)
    );

    oki_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (coef_valid),
        .in_ready  (coef_ready),
        .in_coef   (coef),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_speed (m_tdata)
    );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Testbench for omni_wheel_inverse_kinematics_top: drives heading and velocity commands on the
// s_ stream, predicts the three wheel speeds in fixed point and checks every m_ transfer.
// Depends on oki_pkg and the top level only.
`timescale 1ns / 1ps

module testbench;
    import oki_pkg::*;

    localparam int                F           = TRIG_FRAC_BITS;
    localparam longint unsigned   UNIT_Q30    = 64'd1 << 30;
    localparam longint unsigned   PI_IN_Q30   = 64'd3373259426;
    localparam longint unsigned   ROOT3_HALF  = 64'd929887697;
    localparam longint            WHEEL_MAX   = 64'sd8388607;
    localparam longint            WHEEL_MIN   = -64'sd8388608;
    localparam int                MAX_WAIT    = 18;
    localparam int                SETTLE_CYC  = 24;

    // wheel0 in the low bits, as on m_tdata
    typedef struct packed {
        logic signed [SPEED_W-1:0] w2;
        logic signed [SPEED_W-1:0] w1;
        logic signed [SPEED_W-1:0] w0;
    } wheel_speeds_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [15:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;

    wheel_speeds_t pending_speeds[$];
    logic [15:0]   radius_gain;
    int            mismatch_count;
    int            result_count;
    bit            tx_no_gaps;
    bit            rx_no_stalls;

    omni_wheel_inverse_kinematics_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- prediction
    function automatic longint unsigned taylor_sin(input longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 30;
        t = UNIT_Q30 - x2 / 72;
        t = UNIT_Q30 - ((x2 * t) >> 30) / 42;
        t = UNIT_Q30 - ((x2 * t) >> 30) / 20;
        t = UNIT_Q30 - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    function automatic longint unsigned taylor_cos(input longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 30;
        t = UNIT_Q30 - x2 / 90;
        t = UNIT_Q30 - ((x2 * t) >> 30) / 56;
        t = UNIT_Q30 - ((x2 * t) >> 30) / 30;
        t = UNIT_Q30 - ((x2 * t) >> 30) / 12;
        t = UNIT_Q30 - ((x2 * t) >> 30) / 2;
        return t;
    endfunction

    function automatic longint q30_to_trig(input longint unsigned v);
        return longint'((v + (64'd1 << (29 - F))) >> (30 - F));
    endfunction

    function automatic longint coef_round(input longint v);
        return (v + (64'sd1 <<< (F - 1))) >>> F;
    endfunction

    function automatic logic signed [SPEED_W-1:0] clamp_speed(input longint neg_cmd);
        longint one_f;
        longint v;
        one_f = 64'sd1 <<< F;
        v = neg_cmd / one_f;            // truncates toward zero
        if (v > WHEEL_MAX) v = WHEEL_MAX;
        if (v < WHEEL_MIN) v = WHEEL_MIN;
        return SPEED_W'(v);
    endfunction

    function automatic wheel_speeds_t predict_wheel_speeds(input logic [15:0] heading,
                                                           input logic signed [15:0] vx,
                                                           input logic signed [15:0] vy,
                                                           input logic signed [15:0] rate,
                                                           input logic [15:0] gain);
        longint unsigned offs;
        longint unsigned x;
        longint          sb, cb, s, c, k, half, turn;
        longint          sk0, ck0, sk1, ck1, sk2, ck2;
        wheel_speeds_t   res;
        offs = longint'(heading[13:0]);
        // fold to the first octant; the boundary itself stays unswapped
        if (offs <= 8192) begin
            x  = (offs * PI_IN_Q30) >> 15;
            sb = q30_to_trig(taylor_sin(x));
            cb = q30_to_trig(taylor_cos(x));
        end else begin
            x  = ((64'd16384 - offs) * PI_IN_Q30) >> 15;
            sb = q30_to_trig(taylor_cos(x));
            cb = q30_to_trig(taylor_sin(x));
        end
        case (oki_quad_t'(heading[15:14]))
            QUAD_FIRST:  begin s = sb;  c = cb;  end
            QUAD_SECOND: begin s = cb;  c = -sb; end
            QUAD_THIRD:  begin s = -sb; c = -cb; end
            default:     begin s = -cb; c = sb;  end
        endcase
        k    = q30_to_trig(ROOT3_HALF);
        half = 64'sd1 <<< (F - 1);
        sk0  = coef_round(s * k + c * half);
        ck0  = coef_round(c * k - s * half);
        sk1  = coef_round(-s * k + c * half);
        ck1  = coef_round(-c * k - s * half);
        sk2  = -c;
        ck2  = s;
        turn = longint'(gain) * longint'(rate) * (64'sd1 <<< (F - 8));
        res.w0 = clamp_speed(sk0 * longint'(vx) - ck0 * longint'(vy) - turn);
        res.w1 = clamp_speed(sk1 * longint'(vx) - ck1 * longint'(vy) - turn);
        res.w2 = clamp_speed(sk2 * longint'(vx) - ck2 * longint'(vy) - turn);
        return res;
    endfunction

    // ---------------------------------------------------------------- result side
    task automatic report_mismatch(input string field, input logic signed [SPEED_W-1:0] want,
                                   input logic signed [SPEED_W-1:0] got);
        $display("result %0d: %s expected %0d, got %0d", result_count, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_results
        wheel_speeds_t got;
        wheel_speeds_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_speeds.size() == 0) begin
                $display("result %0d: transfer with nothing expected", result_count);
                mismatch_count++;
            end else begin
                want = pending_speeds.pop_front();
                if (got.w0 !== want.w0) report_mismatch("wheel0_speed", want.w0, got.w0);
                if (got.w1 !== want.w1) report_mismatch("wheel1_speed", want.w1, got.w1);
                if (got.w2 !== want.w2) report_mismatch("wheel2_speed", want.w2, got.w2);
            end
            result_count++;
        end
    end

    // unless rx_no_stalls is set, stall the result side for a random number of cycles before each transfer
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        forever begin
            stall = rx_no_stalls ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
        end
    end

    // ---------------------------------------------------------------- command side
    // Returns just after the edge that accepted the transfer; s_tvalid is left high
    task automatic drive_command(input logic [15:0] heading, input logic [15:0] vx,
                                 input logic [15:0] vy, input logic [15:0] rate);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rate, vy, vx, heading};
        do @(posedge aclk); while (!s_tready);
        pending_speeds.push_back(predict_wheel_speeds(heading, vx, vy, rate, radius_gain));
    endtask

    task automatic settle_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_speeds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_radius_gain(input logic [15:0] gain);
        settle_pipeline();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= gain;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        radius_gain = gain;
    endtask

    function automatic logic [15:0] pick_velocity();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_command();
        logic [15:0] heading;
        // land on or next to an octant boundary now and then
        if ($urandom_range(0, 4) == 0)
            heading = 16'(($urandom_range(0, 7) << 13) + $urandom_range(0, 2) - 1);
        else
            heading = 16'($urandom);
        drive_command(heading, pick_velocity(), pick_velocity(), pick_velocity());
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        tx_no_gaps   = 1'b0;
        rx_no_stalls = 1'b0;
        // reset gain of 1.0
        drive_command(16'd0,     16'd0,      16'd0,      16'd0);
        drive_command(16'd0,     16'h7FFF,   16'd0,      16'd0);
        drive_command(16'd16384, 16'h8000,   16'd0,      16'd0);
        drive_command(16'd32768, 16'd0,      16'h7FFF,   16'd0);
        drive_command(16'd49152, 16'd0,      16'h8000,   16'd0);
        drive_command(16'd8192,  16'd1000,   -16'd1000,  16'd100);
        drive_command(16'd8191,  16'd1000,   -16'd1000,  16'd100);
        drive_command(16'd8193,  16'd1000,   -16'd1000,  16'd100);
        drive_command(16'd24576, -16'd2000,  16'd3000,   -16'd50);
        drive_command(16'd40960, -16'd2000,  16'd3000,   -16'd50);
        drive_command(16'd57344, -16'd2000,  16'd3000,   -16'd50);
        drive_command(16'hFFFF,  16'h8000,   16'h8000,   16'h8000);
        drive_command(16'd1,     16'h7FFF,   16'h7FFF,   16'h7FFF);
        drive_command(16'd16383, 16'h7FFF,   16'h8000,   16'h7FFF);
        // largest radius: drive the speeds into saturation
        set_radius_gain(16'hFFFF);
        drive_command(16'd0,     16'd0,      16'd0,      16'h7FFF);
        drive_command(16'd0,     16'd0,      16'd0,      16'h8000);
        drive_command(16'd12345, 16'h7FFF,   16'h8000,   16'h8000);
        drive_command(16'd12345, 16'h8000,   16'h7FFF,   16'h7FFF);
        // zero radius: the turn rate drops out
        set_radius_gain(16'd0);
        drive_command(16'd40000, 16'h7FFF,   16'h7FFF,   16'h7FFF);
        drive_command(16'd8192,  16'h8000,   16'h8000,   16'h8000);
    endtask

    task automatic test_gain_sweep();
        logic [15:0] gains [5];
        gains = '{16'd1, 16'hFFFF, 16'd0, 16'd128, 16'($urandom)};
        foreach (gains[i]) begin
            set_radius_gain(gains[i]);
            tx_no_gaps   = ($urandom_range(0, 2) == 0);
            rx_no_stalls = ($urandom_range(0, 2) == 0);
            repeat (30) send_random_command();
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 9; phase++) begin
            set_radius_gain(($urandom_range(0, 3) == 0) ? 16'd256 : 16'($urandom));
            // mix back-to-back bursts and an always-ready result side with random gaps and stalls
            tx_no_gaps   = ($urandom_range(0, 2) == 0);
            rx_no_stalls = ($urandom_range(0, 2) == 0);
            repeat (45) send_random_command();
        end
    endtask

    initial begin : timeout_guard
        #(2_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : run_tests
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 16'd0;
        s_tvalid       = 1'b0;
        s_tdata        = 64'd0;
        radius_gain    = 16'd256;
        mismatch_count = 0;
        result_count   = 0;
        tx_no_gaps     = 1'b0;
        rx_no_stalls   = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_gain_sweep();
        test_random_traffic();
        settle_pipeline();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
